### src/fcce_pkg.sv
// ---------------------------------------------------------------------------
// fcce_pkg
// Shared types and constants for the cluster chain engine: table geometry,
// entry codes, request modes, sequencer states and the table write port.
// ---------------------------------------------------------------------------
package fcce_pkg;

   // table geometry
   localparam int MAX_CLUSTERS = 4096;
   localparam int TABLE_DEPTH  = MAX_CLUSTERS + 2;
   localparam int ADDR_W       = $clog2(TABLE_DEPTH);
   localparam int CL_W         = 13;
   localparam int ENTRY_W      = 28;
   localparam int MODE_W       = 3;

   typedef logic [CL_W-1:0]    clus_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [ENTRY_W-1:0] entry_type;

   // entry codes
   localparam entry_type END_MARK   = 28'hFFF_FFFF;
   localparam entry_type END_MIN    = 28'hFFF_FFF8;
   localparam entry_type FREE_ENTRY = '0;
   localparam clus_type  FIRST_DATA = clus_type'(2);
   localparam clus_type  MAX_TOTAL  = clus_type'(MAX_CLUSTERS);
   localparam addr_type  LAST_ADDR  = addr_type'(TABLE_DEPTH - 1);

   // request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_READ   = 3'd0,
      MODE_WRITE  = 3'd1,
      MODE_ALLOC  = 3'd2,
      MODE_FREE   = 3'd3,
      MODE_LENGTH = 3'd4,
      MODE_COUNT  = 3'd5
   } mode_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_SCAN,
      ST_WALK_CHECK,
      ST_WALK_DATA
   } state_type;

   // table write port
   typedef struct packed {
      logic      en;
      addr_type  addr;
      entry_type data;
   } tbl_wr_type;

endpackage

### src/fcce_table.sv
// ---------------------------------------------------------------------------
// fcce_table
// Allocation table storage: one write port and one read port with
// registered read data. Only the low 28 bits of an entry are kept.
// ---------------------------------------------------------------------------
module fcce_table (
   input  logic                 clock,
   input  fcce_pkg::tbl_wr_type wr,
   input  logic                 rd_en,
   input  fcce_pkg::addr_type   rd_addr,
   output fcce_pkg::entry_type  rd_data
);
   import fcce_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fat_cluster_chain_engine.sv
// ---------------------------------------------------------------------------
// fat_cluster_chain_engine
// FAT32 cluster allocation table with read, write, allocate, free chain,
// chain length and free count requests, run by a small sequencer over one
// table read port and one compare unit.
// ---------------------------------------------------------------------------
// allocate and count free scan the table at one table read a cycle; free chain
//   and chain length walk the chain, each link waiting for its own table read
// one request at a time, busy stays high until the result strobe
// reset starts a clearing pass over the table, busy high meanwhile;
//   csr writes are taken at any time; the receiver cannot stall results
module fat_cluster_chain_engine (
   input  logic                       clock,
   input  logic                       reset,
   // request
   input  logic                       start,
   output logic                       busy,
   input  logic [fcce_pkg::MODE_W-1:0] req_mode,
   input  fcce_pkg::clus_type         req_cluster,
   input  fcce_pkg::entry_type        req_value,
   // response
   output logic                       rsp_valid,
   output fcce_pkg::entry_type        rsp_entry_value,
   output fcce_pkg::clus_type         rsp_found_cluster,
   output fcce_pkg::clus_type         rsp_count,
   output logic                       rsp_ok,
   // configuration
   input  logic                       csr_wr_en,
   input  fcce_pkg::clus_type         csr_wr_data
);
   import fcce_pkg::*;

   state_type  state_ff, state_in;
   mode_type   mode_ff, mode_in;
   clus_type   cl_ff, cl_in;
   entry_type  val_ff, val_in;
   addr_type   addr_ff, addr_in;
   logic       pend_ff, pend_in;
   addr_type   pend_addr_ff, pend_addr_in;
   entry_type  cur_ff, cur_in;
   clus_type   n_ff, n_in;
   clus_type   total_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   entry_type  rsp_entry_ff, rsp_entry_in;
   clus_type   rsp_found_ff, rsp_found_in;
   clus_type   rsp_count_ff, rsp_count_in;
   logic       rsp_ok_ff, rsp_ok_in;

   tbl_wr_type tbl_wr;
   logic       rd_en;
   addr_type   rd_addr;
   entry_type  rd_data;

   clus_type   eff_total;
   clus_type   last_cl;
   logic       cl_in_table;
   logic       hit;
   logic       fin;
   entry_type  fin_entry;
   clus_type   fin_found;
   clus_type   fin_count;
   logic       fin_ok;

   // table storage
   fcce_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= MAX_TOTAL;
      end else if (csr_wr_en) begin
         total_ff <= csr_wr_data;
      end
   end

   // table bounds
   assign eff_total   = (total_ff > MAX_TOTAL) ? MAX_TOTAL : total_ff;
   assign last_cl     = eff_total + clus_type'(1);
   assign cl_in_table = (cl_ff <= last_cl);
   assign hit         = pend_ff && (rd_data == FREE_ENTRY);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      cl_ff        <= cl_in;
      val_ff       <= val_in;
      pend_addr_ff <= pend_addr_in;
      cur_ff       <= cur_in;
      n_ff         <= n_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   // sequencer: next state and outputs
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cl_in        = cl_ff;
      val_in       = val_ff;
      addr_in      = addr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      cur_in       = cur_ff;
      n_in         = n_ff;
      rsp_valid_in = 1'b0;
      rsp_entry_in = rsp_entry_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ok_in    = rsp_ok_ff;
      tbl_wr.en    = 1'b0;
      tbl_wr.addr  = cl_ff[ADDR_W-1:0];
      tbl_wr.data  = val_ff;
      rd_en        = 1'b0;
      rd_addr      = cl_ff[ADDR_W-1:0];
      fin          = 1'b0;
      fin_entry    = '0;
      fin_found    = '0;
      fin_count    = '0;
      fin_ok       = 1'b0;

      case (state_ff)
         // clear the table one entry a cycle
         ST_CLEAR: begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = addr_ff;
            tbl_wr.data = FREE_ENTRY;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + addr_type'(1);
            end
         end
         // request transfer
         ST_IDLE: begin
            if (start) begin
               mode_in  = mode_type'(req_mode);
               cl_in    = req_cluster;
               val_in   = req_value;
               state_in = ST_DISPATCH;
            end
         end
         // decode the mode
         ST_DISPATCH: begin
            case (mode_ff)
               MODE_READ: begin
                  if (cl_in_table) begin
                     rd_en    = 1'b1;
                     state_in = ST_READ;
                  end else begin
                     fin = 1'b1;
                  end
               end
               MODE_WRITE: begin
                  fin       = 1'b1;
                  tbl_wr.en = cl_in_table;
                  fin_ok    = cl_in_table;
               end
               MODE_ALLOC, MODE_COUNT: begin
                  addr_in  = FIRST_DATA[ADDR_W-1:0];
                  pend_in  = 1'b0;
                  n_in     = '0;
                  state_in = ST_SCAN;
               end
               MODE_FREE, MODE_LENGTH: begin
                  cur_in   = entry_type'(cl_ff);
                  n_in     = '0;
                  state_in = ST_WALK_CHECK;
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         // read data is back
         ST_READ: begin
            fin       = 1'b1;
            fin_entry = rd_data;
            fin_ok    = 1'b1;
         end
         // linear scan: issue one read a cycle, check the one issued before
         ST_SCAN: begin
            if (mode_ff == MODE_ALLOC && hit) begin
               tbl_wr.en   = 1'b1;
               tbl_wr.addr = pend_addr_ff;
               tbl_wr.data = END_MARK;
               pend_in     = 1'b0;
               fin         = 1'b1;
               fin_found   = clus_type'(pend_addr_ff);
               fin_ok      = 1'b1;
            end else begin
               if (hit) begin
                  n_in = n_ff + clus_type'(1);
               end
               if (clus_type'(addr_ff) <= last_cl) begin
                  rd_en        = 1'b1;
                  rd_addr      = addr_ff;
                  pend_in      = 1'b1;
                  pend_addr_in = addr_ff;
                  addr_in      = addr_ff + addr_type'(1);
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     fin       = 1'b1;
                     fin_count = (mode_ff == MODE_COUNT) ? n_ff : '0;
                     fin_ok    = 1'b1;
                  end
               end
            end
         end
         // chain walk: check the current link and fetch its successor
         ST_WALK_CHECK: begin
            if (cur_ff < entry_type'(FIRST_DATA) || cur_ff >= END_MIN) begin
               fin       = 1'b1;
               fin_count = n_ff;
               fin_ok    = 1'b1;
            end else if (cur_ff > entry_type'(last_cl) || n_ff >= eff_total) begin
               fin       = 1'b1;
               fin_count = n_ff;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = cur_ff[ADDR_W-1:0];
               state_in = ST_WALK_DATA;
            end
         end
         // chain walk: step to the successor, clearing the link when freeing
         ST_WALK_DATA: begin
            tbl_wr.en   = (mode_ff == MODE_FREE);
            tbl_wr.addr = cur_ff[ADDR_W-1:0];
            tbl_wr.data = FREE_ENTRY;
            n_in        = n_ff + clus_type'(1);
            cur_in      = rd_data;
            state_in    = ST_WALK_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // response transfer
      if (fin) begin
         rsp_valid_in = 1'b1;
         rsp_entry_in = fin_entry;
         rsp_found_in = fin_found;
         rsp_count_in = fin_count;
         rsp_ok_in    = fin_ok;
         state_in     = ST_IDLE;
      end
   end

   // outputs
   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_value   = rsp_entry_ff;
   assign rsp_found_cluster = rsp_found_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_ok            = rsp_ok_ff;

endmodule

### test/fat_cluster_chain_engine_test.sv
// ---------------------------------------------------------------------------
// fat_cluster_chain_engine_test
// Self-checking bench for the cluster chain engine. A tracker class keeps its
// own copy of the allocation table and the cluster total, works out the reply
// to every request transfer and checks each reply strobe against the oldest
// reply still awaited. Directed requests cover the edges of the table, chain
// faults and odd register values; random phases then build, link, measure and
// free chains over several table sizes with random sender idling.
// ---------------------------------------------------------------------------
module fat_cluster_chain_engine_test;
   import fcce_pkg::*;

   // modes the block does not define
   localparam logic [MODE_W-1:0] MODE_RSVD_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD_B = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 10_000_000;
   localparam int unsigned END_WAIT    = 20;

   typedef struct packed {
      entry_type entry_value;
      clus_type  found_cluster;
      clus_type  count;
      logic      ok;
   } fat_reply_type;

   // table tracker: predicts replies and checks them in order
   class fat_table_tracker;
      entry_type     image [TABLE_DEPTH];
      clus_type      total_reg;
      fat_reply_type awaited [$];
      clus_type      last_found;
      int unsigned   accepted;
      int unsigned   mode_hits [8];
      int unsigned   walk_faults;
      int unsigned   errors;

      function new();
         foreach (image[i]) image[i] = FREE_ENTRY;
         foreach (mode_hits[i]) mode_hits[i] = 0;
         total_reg   = MAX_TOTAL;
         last_found  = '0;
         accepted    = 0;
         walk_faults = 0;
         errors      = 0;
      endfunction

      function void set_total(clus_type v);
         total_reg = v;
      endfunction

      // clusters in use, oversized register clipped
      function int unsigned span();
         return (total_reg > MAX_TOTAL) ? MAX_CLUSTERS : int'(total_reg);
      endfunction

      // follow a chain, optionally clearing each link after reading it
      function int unsigned walk(int unsigned head, bit clear_links, output bit ok);
         int unsigned total;
         int unsigned last;
         int unsigned cur;
         int unsigned nxt;
         int unsigned links;
         total = span();
         last  = total + 1;
         cur   = head;
         links = 0;
         ok    = 1'b1;
         while (cur >= FIRST_DATA && cur < END_MIN) begin
            // bad link or a loop longer than the table
            if (cur > last || links >= total) begin
               ok = 1'b0;
               break;
            end
            nxt = image[cur];
            if (clear_links) image[cur] = FREE_ENTRY;
            links++;
            cur = nxt;
         end
         return links;
      endfunction

      // note an accepted request and queue its reply
      function void take_request(logic [MODE_W-1:0] mode, clus_type cl, entry_type val);
         fat_reply_type r;
         int unsigned   last;
         int unsigned   c;
         bit            ok;
         last = span() + 1;
         r    = '0;
         r.ok = 1'b1;
         ok   = 1'b1;
         case (mode)
            MODE_READ: begin
               if (cl <= last) r.entry_value = image[cl];
               else r.ok = 1'b0;
            end
            MODE_WRITE: begin
               if (cl <= last) image[cl] = val;
               else r.ok = 1'b0;
            end
            MODE_ALLOC: begin
               for (c = FIRST_DATA; c <= last; c++) begin
                  if (image[c] == FREE_ENTRY) begin
                     image[c] = END_MARK;
                     r.found_cluster = clus_type'(c);
                     break;
                  end
               end
            end
            MODE_FREE: begin
               r.count = clus_type'(walk(cl, 1'b1, ok));
               r.ok = ok;
            end
            MODE_LENGTH: begin
               r.count = clus_type'(walk(cl, 1'b0, ok));
               r.ok = ok;
            end
            MODE_COUNT: begin
               for (c = FIRST_DATA; c <= last; c++) begin
                  if (image[c] == FREE_ENTRY) r.count = r.count + 1'b1;
               end
            end
            default: r.ok = 1'b0;
         endcase
         if (!ok) walk_faults++;
         mode_hits[mode]++;
         accepted++;
         last_found = r.found_cluster;
         awaited.push_back(r);
      endfunction

      function void compare_field(string label, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
         end
      endfunction

      // check one reply strobe against the oldest awaited reply
      function void match_reply(entry_type ev, clus_type fc, clus_type cnt, logic ok);
         fat_reply_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: reply with no request outstanding, got %0h %0h %0h %0b",
                     $time, ev, fc, cnt, ok);
            return;
         end
         want = awaited.pop_front();
         compare_field("entry_value", 32'(want.entry_value), 32'(ev));
         compare_field("found_cluster", 32'(want.found_cluster), 32'(fc));
         compare_field("count", 32'(want.count), 32'(cnt));
         compare_field("ok", 32'(want.ok), 32'(ok));
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [MODE_W-1:0]   req_mode;
   clus_type            req_cluster;
   entry_type           req_value;
   logic                rsp_valid;
   entry_type           rsp_entry_value;
   clus_type            rsp_found_cluster;
   clus_type            rsp_count;
   logic                rsp_ok;
   logic                csr_wr_en;
   clus_type            csr_wr_data;

   fat_table_tracker    tracker = new();
   int unsigned         idle_pct;
   int unsigned         cycle_count;

   fat_cluster_chain_engine i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_cluster       (req_cluster),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_entry_value   (rsp_entry_value),
      .rsp_found_cluster (rsp_found_cluster),
      .rsp_count         (rsp_count),
      .rsp_ok            (rsp_ok),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // reply monitor
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1)
         tracker.match_reply(rsp_entry_value, rsp_found_cluster, rsp_count, rsp_ok);
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d replies awaited", $time, tracker.awaited.size());
      $display("fat_cluster_chain_engine verification failed");
      $finish;
   end

   // random sender gap after a transfer
   task automatic pause_sender();
      int unsigned gap;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // one request transfer
   task automatic issue_request(input logic [MODE_W-1:0] mode, input clus_type cl,
                                input entry_type val);
      start       <= 1'b1;
      req_mode    <= mode;
      req_cluster <= cl;
      req_value   <= val;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.take_request(mode, cl, val);
      pause_sender();
   endtask

   // hold off until every reply is in
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_total(input clus_type total);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= total;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.set_total(total);
   endtask

   // allocate a chain, link it, maybe break it, then measure and maybe free it
   task automatic grow_chain(input int unsigned len);
      clus_type    head;
      clus_type    tail;
      clus_type    fresh;
      int unsigned k;
      int unsigned pick;
      issue_request(MODE_ALLOC, clus_type'($urandom), entry_type'($urandom));
      head = tracker.last_found;
      tail = head;
      if (head != '0) begin
         for (k = 1; k < len; k++) begin
            issue_request(MODE_ALLOC, clus_type'($urandom), entry_type'($urandom));
            fresh = tracker.last_found;
            if (fresh == '0) break;
            issue_request(MODE_WRITE, tail, entry_type'(fresh));
            tail = fresh;
         end
         // sometimes loop back to the head or point past the table
         pick = $urandom_range(0, 99);
         if (pick < 15)
            issue_request(MODE_WRITE, tail, entry_type'(head));
         else if (pick < 25)
            issue_request(MODE_WRITE, tail,
                          entry_type'(tracker.span() + 2 + $urandom_range(0, 3)));
      end
      issue_request(MODE_LENGTH, head, entry_type'($urandom));
      if ($urandom_range(0, 1) == 1)
         issue_request(MODE_FREE, head, entry_type'($urandom));
   endtask

   // single request with loosely shaped content
   task automatic random_request();
      logic [MODE_W-1:0] mode;
      clus_type          cl;
      entry_type         val;
      int unsigned       last;
      int unsigned       pick;
      last = tracker.span() + 1;
      pick = $urandom_range(0, 99);
      if (pick < 20)      mode = MODE_READ;
      else if (pick < 45) mode = MODE_WRITE;
      else if (pick < 60) mode = MODE_ALLOC;
      else if (pick < 72) mode = MODE_FREE;
      else if (pick < 86) mode = MODE_LENGTH;
      else if (pick < 94) mode = MODE_COUNT;
      else if (pick < 97) mode = MODE_RSVD_A;
      else                mode = MODE_RSVD_B;
      // cluster mostly inside the table, sometimes just past it or anywhere
      pick = $urandom_range(0, 99);
      if (pick < 75)      cl = clus_type'($urandom_range(0, last));
      else if (pick < 88) cl = clus_type'(last + $urandom_range(1, 2));
      else                cl = clus_type'($urandom);
      // value mostly a link, else an end code or anything
      pick = $urandom_range(0, 99);
      if (pick < 50)      val = entry_type'($urandom_range(0, last + 2));
      else if (pick < 65) val = END_MARK;
      else if (pick < 75) val = END_MIN + entry_type'($urandom_range(0, 7));
      else                val = entry_type'($urandom);
      issue_request(mode, cl, val);
   endtask

   task automatic run_phase(input clus_type total, input int unsigned items,
                            input int unsigned pct);
      int unsigned first;
      program_total(total);
      idle_pct = pct;
      first = tracker.accepted;
      while (tracker.accepted - first < items) begin
         if ($urandom_range(0, 99) < 35) grow_chain($urandom_range(1, 8));
         else random_request();
         if ($urandom_range(0, 99) < 4) settle();
      end
   endtask

   // stimulus
   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_mode    <= MODE_READ;
      req_cluster <= '0;
      req_value   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      idle_pct    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // full table: edges, reserved entries, bad links
      program_total(MAX_TOTAL);
      issue_request(MODE_COUNT, '0, '0);
      issue_request(MODE_ALLOC, '1, '1);
      issue_request(MODE_ALLOC, '0, '0);
      issue_request(MODE_WRITE, clus_type'(2), entry_type'(3));
      issue_request(MODE_LENGTH, clus_type'(2), '0);
      issue_request(MODE_READ, clus_type'(2), '0);
      issue_request(MODE_WRITE, '0, '1);
      issue_request(MODE_READ, '0, '0);
      issue_request(MODE_WRITE, clus_type'(LAST_ADDR), END_MIN);
      issue_request(MODE_READ, clus_type'(LAST_ADDR), '0);
      issue_request(MODE_READ, clus_type'(TABLE_DEPTH), '0);
      issue_request(MODE_WRITE, '1, entry_type'(5));
      issue_request(MODE_LENGTH, clus_type'(1), '0);
      issue_request(MODE_LENGTH, clus_type'(LAST_ADDR), '0);
      issue_request(MODE_WRITE, clus_type'(3), entry_type'(4500));
      issue_request(MODE_LENGTH, clus_type'(2), '0);
      issue_request(MODE_FREE, clus_type'(2), '0);
      issue_request(MODE_RSVD_A, clus_type'(2), '1);
      issue_request(MODE_RSVD_B, '1, entry_type'(3));

      // no data clusters at all
      program_total('0);
      issue_request(MODE_ALLOC, '0, '0);
      issue_request(MODE_COUNT, '0, '0);
      issue_request(MODE_LENGTH, clus_type'(2), '0);

      // one data cluster: full table and a self loop
      program_total(clus_type'(1));
      issue_request(MODE_ALLOC, '0, '0);
      issue_request(MODE_ALLOC, '0, '0);
      issue_request(MODE_WRITE, clus_type'(2), entry_type'(2));
      issue_request(MODE_LENGTH, clus_type'(2), '0);
      issue_request(MODE_FREE, clus_type'(2), '0);

      // oversized register acts as the largest table
      program_total('1);
      issue_request(MODE_COUNT, '0, '0);
      issue_request(MODE_READ, clus_type'(TABLE_DEPTH), '0);

      // random phases over several sizes and idle rates
      run_phase(clus_type'(16), 12, 0);
      run_phase(clus_type'(5), 8, 45);
      run_phase(MAX_TOTAL, 4, 25);
      run_phase(clus_type'(40), 12, 45);
      run_phase('1, 3, 0);
      run_phase(clus_type'(1), 5, 25);
      run_phase('0, 4, 45);
      run_phase(clus_type'(64), 12, 25);
      run_phase(clus_type'(12), 10, 0);

      settle();
      repeat (END_WAIT) @(posedge clock);
      if (tracker.awaited.size() != 0) begin
         tracker.errors++;
         $display("%0t: %0d replies never arrived", $time, tracker.awaited.size());
      end

      $display("run covered %0d requests: read %0d, write %0d, allocate %0d, free %0d",
               tracker.accepted, tracker.mode_hits[MODE_READ], tracker.mode_hits[MODE_WRITE],
               tracker.mode_hits[MODE_ALLOC], tracker.mode_hits[MODE_FREE]);
      $display("chain length %0d, count free %0d, undefined mode %0d, faulted walks %0d",
               tracker.mode_hits[MODE_LENGTH], tracker.mode_hits[MODE_COUNT],
               tracker.mode_hits[MODE_RSVD_A] + tracker.mode_hits[MODE_RSVD_B],
               tracker.walk_faults);
      if (tracker.errors == 0)
         $display("fat_cluster_chain_engine verification clean");
      else
         $display("fat_cluster_chain_engine verification failed");
      $finish;
   end

endmodule
